### design/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

    // Frame bounds
    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 2);
    localparam int HDR_LEN   = 7;

    // CRC-16/Modbus, reflected form
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Function codes
    localparam logic [7:0] FN_READ  = 8'h03;
    localparam logic [7:0] FN_WRITE = 8'h10;

    // Minimum response lengths per mode
    localparam logic [CNT_W-1:0] READ_MIN_LEN  = CNT_W'(7);
    localparam logic [CNT_W-1:0] WRITE_MIN_LEN = CNT_W'(8);

    // Configuration register map (word index)
    localparam logic [1:0] REG_SLAVE    = 2'd0;
    localparam logic [1:0] REG_MODE     = 2'd1;
    localparam logic [1:0] REG_ADDRESS  = 2'd2;
    localparam logic [1:0] REG_QUANTITY = 2'd3;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_SLAVE     = 3'd2,
        VERDICT_FUNCTION  = 3'd3,
        VERDICT_BYTECOUNT = 3'd4,
        VERDICT_CRC       = 3'd5,
        VERDICT_ADDR_QTY  = 3'd6,
        VERDICT_OVERLONG  = 3'd7
    } verdict_t;

    typedef struct packed {
        logic [7:0]  expected_slave;
        logic        write_mode;
        logic [15:0] expected_address;
        logic [15:0] expected_quantity;
    } cfg_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } result_t;

    // One byte through the CRC, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/modbus_rtu_response_checker.sv
`timescale 1ns / 1ps
// Modbus RTU response checker.
// Input stream: one received frame byte per beat on s_tdata, s_tlast on the
// final byte of the frame. Result stream: one beat per frame, sent after the
// byte flagged by s_tlast, carrying the verdict and two 16-bit words.
// Configuration: APB port with expected slave, mode, address and quantity at
// byte addresses 0x0, 0x4, 0x8 and 0xC; write only while no frame is open.
// Throughput: one byte per cycle, but for a final byte held by a stalled
// result (see below). Each byte lands in an input register, is checked
// against the frame state by a CRC and compare stage, and the verdict
// lands in the result register, which drives m_tvalid. The eight-step CRC
// update sets the critical path.
// When the receiver stalls, the result register holds; non-final bytes keep
// flowing, and a further final byte waits in the input register, holding
// s_tready low, until the result beat is taken.
// Reset (aresetn low, synchronous) drops any frame in progress, empties both
// registers and restores the register defaults (slave 1, read mode, zeros).
module modbus_rtu_response_checker
    import mrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // frame_end
    // Result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] verdict, [18:3] first_word,
                                   // [34:19] second_word, [39:35] zero
);

    cfg_t    cfg;
    result_t result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    logic       m_valid_reg, m_valid_next;
    result_t    m_data_reg;

    mrc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrc_frame_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .beat_en   (advance),
        .beat_byte (in_byte_reg),
        .beat_last (in_last_reg),
        .result    (result)
    );

    // Advance the input beat unless it is final and the result slot is full and not being taken
    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
        m_valid_next = m_valid_reg;
        if (advance && in_last_reg) m_valid_next = 1'b1;
        else if (m_tready)          m_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) m_data_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg.second_word, m_data_reg.first_word,
                       m_data_reg.verdict};

endmodule

### design/mrc_cfg_regs.sv
`timescale 1ns / 1ps

module mrc_cfg_regs
    import mrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_SLAVE:    cfg_next.expected_slave    = pwdata[7:0];
                REG_MODE:     cfg_next.write_mode        = pwdata[0];
                REG_ADDRESS:  cfg_next.expected_address  = pwdata[15:0];
                REG_QUANTITY: cfg_next.expected_quantity = pwdata[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_slave    <= 8'd1;
            cfg_reg.write_mode        <= 1'b0;
            cfg_reg.expected_address  <= 16'd0;
            cfg_reg.expected_quantity <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3:2])
            REG_SLAVE:    prdata = {24'd0, cfg_reg.expected_slave};
            REG_MODE:     prdata = {31'd0, cfg_reg.write_mode};
            REG_ADDRESS:  prdata = {16'd0, cfg_reg.expected_address};
            REG_QUANTITY: prdata = {16'd0, cfg_reg.expected_quantity};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

### design/mrc_frame_check.sv
`timescale 1ns / 1ps

module mrc_frame_check
    import mrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       beat_en,
    input  logic [7:0] beat_byte,
    input  logic       beat_last,
    output result_t    result
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       tail_reg [2];
    logic [7:0]       tail_next [2];
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       hdr_next [HDR_LEN];
    logic [7:0]       hdr_cur [HDR_LEN];

    logic [CNT_W-1:0] len;
    logic [15:0]      crc_upd;
    logic [15:0]      rx_crc;
    logic [15:0]      w1, w2;
    logic             bc_short;

    // Per-byte updates: header capture, delayed CRC, saturating count
    always_comb begin
        len     = (count_reg < CNT_W'(MAX_FRAME + 1)) ? count_reg + CNT_W'(1) : count_reg;
        crc_upd = (count_reg >= CNT_W'(2)) ? crc_byte(crc_reg, tail_reg[1]) : crc_reg;
        rx_crc  = {beat_byte, tail_reg[0]};
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr_cur[i] = (count_reg == CNT_W'(i)) ? beat_byte : hdr_reg[i];
        end
        bc_short = len < (CNT_W'(5) + CNT_W'(hdr_cur[2]));
    end

    // Verdict in check order per mode
    always_comb begin
        result.verdict = VERDICT_OK;
        if (cfg.write_mode) begin
            w1 = {hdr_cur[2], hdr_cur[3]};
            w2 = {hdr_cur[4], hdr_cur[5]};
            priority if (len > CNT_W'(MAX_FRAME))             result.verdict = VERDICT_OVERLONG;
            else if (len < WRITE_MIN_LEN)                     result.verdict = VERDICT_SHORT;
            else if (hdr_cur[0] != cfg.expected_slave)        result.verdict = VERDICT_SLAVE;
            else if (hdr_cur[1] != FN_WRITE)                  result.verdict = VERDICT_FUNCTION;
            else if (crc_upd != rx_crc)                       result.verdict = VERDICT_CRC;
            else if (w1 != cfg.expected_address || w2 != cfg.expected_quantity)
                                                              result.verdict = VERDICT_ADDR_QTY;
            else                                              result.verdict = VERDICT_OK;
        end else begin
            w1 = {hdr_cur[3], hdr_cur[4]};
            w2 = {hdr_cur[5], hdr_cur[6]};
            priority if (len > CNT_W'(MAX_FRAME))             result.verdict = VERDICT_OVERLONG;
            else if (len < READ_MIN_LEN)                      result.verdict = VERDICT_SHORT;
            else if (hdr_cur[0] != cfg.expected_slave)        result.verdict = VERDICT_SLAVE;
            else if (hdr_cur[1] != FN_READ)                   result.verdict = VERDICT_FUNCTION;
            else if (bc_short)                                result.verdict = VERDICT_BYTECOUNT;
            else if (crc_upd != rx_crc)                       result.verdict = VERDICT_CRC;
            else                                              result.verdict = VERDICT_OK;
        end
        result.first_word  = w1;
        result.second_word = w2;
    end

    // Advance frame state, clear it after the last beat
    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        hdr_next   = hdr_reg;
        if (beat_en) begin
            if (beat_last) begin
                count_next = '0;
                crc_next   = CRC_INIT;
                tail_next  = '{8'd0, 8'd0};
                for (int i = 0; i < HDR_LEN; i++) hdr_next[i] = 8'd0;
            end else begin
                count_next   = len;
                crc_next     = crc_upd;
                tail_next[1] = tail_reg[0];
                tail_next[0] = beat_byte;
                hdr_next     = hdr_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            tail_reg  <= '{8'd0, 8'd0};
            for (int i = 0; i < HDR_LEN; i++) hdr_reg[i] <= 8'd0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule
